// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

	localparam logic [1:0] KIND_PUT  = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_POST = 2'd2;

	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_BLANK = 8'h20;

	// Grey on black.
	localparam logic [7:0] RESET_ATTR = 8'h07;

	localparam logic [7:0] HEX_DIGITS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_PLACE,
		ST_BACK,
		ST_ATTR_RD,
		ST_ATTR_WR,
		ST_SCR_COPY,
		ST_SCR_BLANK,
		ST_SCR_END,
		ST_POST_HI,
		ST_POST_LO,
		ST_DONE
	} tcw_state_t;

	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_ADV,
		CUR_NL,
		CUR_BS,
		CUR_BOT
	} cur_cmd_t;

	typedef struct packed {
		logic adv_end;
		logic nl_end;
	} cur_flags_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		return HEX_DIGITS[nib];
	endfunction

endpackage

// ----- rtl/text_console_writer_core.sv -----
// Channel   Handshake            Payload
// request   start / busy         kind, char_code, cell_index, post_value
// result    done (one cycle)     cursor_cell, cell_char, cell_attr
// config    cfg_we               cfg_wdata (text attribute)
//
// After reset the block sweeps the screen memory to blanks, one cell a cycle,
// so busy stays high until the sweep is over and the first request can be taken.
// A scroll replaces the final cursor attribute update, except when it falls
// inside a tab with blanks still to place; every cell moves through the one
// read port and the one write port of the screen memory.
// Results cannot be stalled; busy is low again the cycle after done.
module text_console_writer_core import tcw_pkg::*; #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 8,
	localparam int CELLS = COLUMNS * ROWS,
	localparam int CW    = $clog2(CELLS + 1),
	localparam int AW    = $clog2(CELLS),
	localparam int PW    = $clog2(TAB_STOP)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [1:0]    kind,
	input  logic [7:0]    char_code,
	input  logic [CW-1:0] cell_index,
	input  logic [7:0]    post_value,
	output logic          done,
	output logic [CW-1:0] cursor_cell,
	output logic [7:0]    cell_char,
	output logic [7:0]    cell_attr,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_wdata
);

	logic [7:0] text_attr_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [15:0]   mem_rdata;

	cur_cmd_t      cur_cmd;
	logic [CW-1:0] cur_pos;
	logic [PW-1:0] cur_ph;
	cur_flags_t    cur_flags;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q <= RESET_ATTR;
		end else if (cfg_we) begin
			text_attr_q <= cfg_wdata;
		end
	end

	tcw_ram #(
		.DEPTH(CELLS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tcw_cursor #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cur_cmd),
		.pos    (cur_pos),
		.phase  (cur_ph),
		.flags  (cur_flags)
	);

	tcw_seq #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.char_code   (char_code),
		.cell_index  (cell_index),
		.post_value  (post_value),
		.text_attr   (text_attr_q),
		.done        (done),
		.cursor_cell (cursor_cell),
		.cell_char   (cell_char),
		.cell_attr   (cell_attr),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata),
		.cur_cmd     (cur_cmd),
		.cur_pos     (cur_pos),
		.cur_ph      (cur_ph),
		.cur_flags   (cur_flags)
	);

endmodule

// ----- rtl/tcw_ram.sv -----
module tcw_ram #(
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/tcw_cursor.sv -----
module tcw_cursor import tcw_pkg::*; #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 8,
	localparam int CELLS = COLUMNS * ROWS,
	localparam int CW    = $clog2(CELLS + 1),
	localparam int PW    = $clog2(TAB_STOP)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cur_cmd_t      cmd,
	output logic [CW-1:0] pos,
	output logic [PW-1:0] phase,
	output cur_flags_t    flags
);

	localparam int COLW   = $clog2(COLUMNS);
	localparam int BOT    = COLUMNS * (ROWS - 1);
	localparam int CM     = COLUMNS % TAB_STOP;
	localparam int BOT_PH = BOT % TAB_STOP;

	logic [CW-1:0]   pos_q;
	logic [COLW-1:0] col_q;
	logic [PW-1:0]   ph_q;
	logic [PW-1:0]   rph_q;

	logic [CW-1:0] row_start;
	logic [PW:0]   sum_up;
	logic [PW:0]   sum_dn;
	logic [PW-1:0] rph_up;
	logic [PW-1:0] rph_dn;
	logic [PW-1:0] ph_inc;
	logic [PW-1:0] ph_dec;

	// The column and the tab phases of the cursor and of its row start are
	// tracked alongside the cell index, so no divide by COLUMNS is needed.
	always_comb begin
		row_start = pos_q - CW'(col_q);
		sum_up = {1'b0, rph_q} + (PW + 1)'(CM);
		sum_dn = {1'b0, rph_q} + (PW + 1)'(TAB_STOP - CM);
		rph_up = (sum_up >= (PW + 1)'(TAB_STOP)) ? PW'(sum_up - (PW + 1)'(TAB_STOP))
			: PW'(sum_up);
		rph_dn = (sum_dn >= (PW + 1)'(TAB_STOP)) ? PW'(sum_dn - (PW + 1)'(TAB_STOP))
			: PW'(sum_dn);
		ph_inc = (ph_q == PW'(TAB_STOP - 1)) ? '0 : ph_q + PW'(1);
		ph_dec = (ph_q == '0) ? PW'(TAB_STOP - 1) : ph_q - PW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			col_q <= '0;
			ph_q  <= '0;
			rph_q <= '0;
		end else begin
			case (cmd)
				CUR_ADV: begin
					pos_q <= pos_q + CW'(1);
					ph_q  <= ph_inc;
					if (col_q == COLW'(COLUMNS - 1)) begin
						col_q <= '0;
						rph_q <= rph_up;
					end else begin
						col_q <= col_q + COLW'(1);
					end
				end
				CUR_NL: begin
					pos_q <= row_start + CW'(COLUMNS);
					col_q <= '0;
					rph_q <= rph_up;
					ph_q  <= rph_up;
				end
				CUR_BS: begin
					if (pos_q != '0) begin
						pos_q <= pos_q - CW'(1);
						ph_q  <= ph_dec;
						if (col_q == '0) begin
							col_q <= COLW'(COLUMNS - 1);
							rph_q <= rph_dn;
						end else begin
							col_q <= col_q - COLW'(1);
						end
					end
				end
				CUR_BOT: begin
					pos_q <= CW'(BOT);
					col_q <= '0;
					ph_q  <= PW'(BOT_PH);
					rph_q <= PW'(BOT_PH);
				end
				default: begin
				end
			endcase
		end
	end

	assign pos           = pos_q;
	assign phase         = ph_q;
	assign flags.adv_end = (pos_q == CW'(CELLS - 1));
	assign flags.nl_end  = (row_start == CW'(BOT));

endmodule

// ----- rtl/tcw_seq.sv -----
module tcw_seq import tcw_pkg::*; #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 8,
	localparam int CELLS = COLUMNS * ROWS,
	localparam int CW    = $clog2(CELLS + 1),
	localparam int AW    = $clog2(CELLS),
	localparam int PW    = $clog2(TAB_STOP)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [1:0]    kind,
	input  logic [7:0]    char_code,
	input  logic [CW-1:0] cell_index,
	input  logic [7:0]    post_value,
	input  logic [7:0]    text_attr,
	output logic          done,
	output logic [CW-1:0] cursor_cell,
	output logic [7:0]    cell_char,
	output logic [7:0]    cell_attr,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [15:0]   mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  logic [15:0]   mem_rdata,
	output cur_cmd_t      cur_cmd,
	input  logic [CW-1:0] cur_pos,
	input  logic [PW-1:0] cur_ph,
	input  cur_flags_t    cur_flags
);

	localparam int RW = $clog2(TAB_STOP + 1);
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0] POST_CELL = AW'(CELLS - 2);
	localparam logic [AW-1:0] FIRST_SRC = AW'(COLUMNS);
	localparam logic [AW-1:0] BOT_CELL  = AW'(COLUMNS * (ROWS - 1));

	tcw_state_t state_q, state_d;

	logic [AW-1:0] sc_q;
	logic [RW-1:0] rem_q;
	logic          bs_q;
	logic          rd_ok_q;
	logic [1:0]    kind_q;
	logic [7:0]    char_q;
	logic [CW-1:0] idx_q;
	logic [7:0]    post_q;
	logic [7:0]    dat_q;

	// Scroll pipeline: the read issued in one cycle is written back a row
	// higher in the next.
	logic          v_s1;
	logic [AW-1:0] wa_s1;
	logic          fm_s1;

	logic [AW-1:0] pos_a;
	logic [AW-1:0] attr_addr;
	logic [AW-1:0] bs_addr;
	logic          idx_ok;

	assign pos_a     = cur_pos[AW-1:0];
	assign attr_addr = pos_a + AW'(bs_q);
	assign bs_addr   = (cur_pos == '0) ? '0 : pos_a - AW'(1);
	assign idx_ok    = (idx_q < CW'(CELLS));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sc_q == LAST_CELL) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (kind_q)
					KIND_PUT: begin
						case (char_q)
							CH_NL:   state_d = cur_flags.nl_end ? ST_SCR_COPY : ST_ATTR_RD;
							CH_BS:   state_d = ST_BACK;
							default: state_d = ST_PLACE;
						endcase
					end
					KIND_POST: state_d = ST_POST_HI;
					default:   state_d = ST_DONE;
				endcase
			end
			ST_PLACE: begin
				if (cur_flags.adv_end) begin
					state_d = ST_SCR_COPY;
				end else if (rem_q > RW'(1)) begin
					state_d = ST_PLACE;
				end else begin
					state_d = ST_ATTR_RD;
				end
			end
			ST_BACK:    state_d = ST_ATTR_RD;
			ST_ATTR_RD: state_d = ST_ATTR_WR;
			ST_ATTR_WR: state_d = ST_DONE;
			ST_SCR_COPY: begin
				if (sc_q == LAST_CELL) begin
					state_d = ST_SCR_BLANK;
				end
			end
			ST_SCR_BLANK: begin
				if (sc_q == LAST_CELL) begin
					state_d = ST_SCR_END;
				end
			end
			ST_SCR_END: state_d = (rem_q != '0) ? ST_PLACE : ST_DONE;
			ST_POST_HI: state_d = ST_POST_LO;
			ST_POST_LO: state_d = ST_DONE;
			ST_DONE:    state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Reads and writes to the same cell never share a cycle: every read of a
	// cell comes in a later cycle than its last write.
	always_comb begin
		busy      = 1'b1;
		done      = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		cur_cmd   = CUR_HOLD;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = sc_q;
				mem_wdata = {RESET_ATTR, CH_BLANK};
			end
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_DISPATCH: begin
				if (kind_q == KIND_PUT && char_q == CH_NL) begin
					cur_cmd = CUR_NL;
				end
				if (kind_q == KIND_READ && idx_ok) begin
					mem_re    = 1'b1;
					mem_raddr = idx_q[AW-1:0];
				end
			end
			ST_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = pos_a;
				mem_wdata = {text_attr, dat_q};
				cur_cmd   = CUR_ADV;
			end
			ST_BACK: begin
				mem_we    = 1'b1;
				mem_waddr = bs_addr;
				mem_wdata = {text_attr, CH_BLANK};
				cur_cmd   = CUR_BS;
			end
			ST_ATTR_RD: begin
				mem_re    = 1'b1;
				mem_raddr = attr_addr;
			end
			ST_ATTR_WR: begin
				mem_we    = 1'b1;
				mem_waddr = attr_addr;
				mem_wdata = {text_attr, mem_rdata[7:0]};
			end
			ST_SCR_COPY: begin
				mem_re    = 1'b1;
				mem_raddr = sc_q;
			end
			ST_SCR_END: begin
				cur_cmd = CUR_BOT;
			end
			ST_POST_HI: begin
				mem_we    = 1'b1;
				mem_waddr = POST_CELL;
				mem_wdata = {text_attr, hex_char(post_q[7:4])};
			end
			ST_POST_LO: begin
				mem_we    = 1'b1;
				mem_waddr = LAST_CELL;
				mem_wdata = {text_attr, hex_char(post_q[3:0])};
			end
			ST_DONE: begin
				done = 1'b1;
			end
			default: begin
			end
		endcase
		if (v_s1) begin
			mem_we    = 1'b1;
			mem_waddr = wa_s1;
			mem_wdata = fm_s1 ? mem_rdata : {text_attr, CH_BLANK};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			sc_q    <= '0;
			rem_q   <= '0;
			bs_q    <= 1'b0;
			rd_ok_q <= 1'b0;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == ST_SCR_COPY) || (state_q == ST_SCR_BLANK);
			case (state_q)
				ST_CLEAR: begin
					sc_q <= sc_q + AW'(1);
				end
				ST_IDLE: begin
					bs_q <= 1'b0;
				end
				ST_DISPATCH: begin
					rd_ok_q <= (kind_q == KIND_READ) && idx_ok;
					case (char_q)
						CH_NL: begin
							rem_q <= '0;
							sc_q  <= FIRST_SRC;
						end
						CH_TAB:  rem_q <= RW'(TAB_STOP) - RW'(cur_ph);
						default: rem_q <= RW'(1);
					endcase
				end
				ST_PLACE: begin
					rem_q <= rem_q - RW'(1);
					if (cur_flags.adv_end) begin
						sc_q <= FIRST_SRC;
					end
				end
				ST_BACK: begin
					bs_q <= 1'b1;
				end
				ST_SCR_COPY: begin
					sc_q <= (sc_q == LAST_CELL) ? BOT_CELL : sc_q + AW'(1);
				end
				ST_SCR_BLANK: begin
					sc_q <= sc_q + AW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			kind_q <= kind;
			char_q <= char_code;
			idx_q  <= cell_index;
			post_q <= post_value;
		end
		if (state_q == ST_DISPATCH) begin
			dat_q <= (char_q == CH_TAB) ? CH_BLANK : char_q;
		end
		wa_s1 <= (state_q == ST_SCR_COPY) ? sc_q - FIRST_SRC : sc_q;
		fm_s1 <= (state_q == ST_SCR_COPY);
	end

	assign cursor_cell = cur_pos;
	assign cell_char   = rd_ok_q ? mem_rdata[7:0] : '0;
	assign cell_attr   = rd_ok_q ? mem_rdata[15:8] : '0;

`ifndef SYNTHESIS
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re && mem_waddr == mem_raddr))
		else $error("read and write of the same cell in one cycle");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (cur_pos < CW'(CELLS)))
		else $error("cursor beyond the screen while idle");

	a_scroll_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == ST_SCR_COPY || state_q == ST_SCR_BLANK ||
			state_q == ST_SCR_END))
		else $error("scroll write outside of a scroll");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start) |=> busy)
		else $error("busy not raised after an accepted request");
`endif

endmodule

// ----- tb/text_console_checker.sv -----
module text_console_checker import tcw_pkg::*; #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  kind,
	input  logic [7:0]  char_code,
	input  logic [10:0] cell_index,
	input  logic [7:0]  post_value,
	input  logic        done,
	input  logic [10:0] cursor_cell,
	input  logic [7:0]  cell_char,
	input  logic [7:0]  cell_attr,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	output int          mismatches,
	output int          outstanding,
	output int          checked,
	output int          scrolls
);

	localparam int CELLS = COLUMNS * ROWS;

	typedef struct packed {
		logic [10:0] cursor;
		logic [7:0]  ch;
		logic [7:0]  attr;
	} cell_answer_t;

	cell_answer_t answer_q[$];

	// Screen image as {attribute, character}, plus cursor and attribute register.
	logic [15:0] screen [CELLS];
	int unsigned cursor_pos;
	logic [7:0] text_attr;

	int err_total = 0;
	int checked_total = 0;
	int scroll_total = 0;

	function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
		return (nib < 4'd10) ? 8'h30 + {4'h0, nib} : 8'h37 + {4'h0, nib};
	endfunction

	task automatic report_mismatch(input string what);
		$display("checker: %0t: %s", $time, what);
		err_total++;
	endtask

	task automatic clear_screen();
		for (int i = 0; i < CELLS; i++)
			screen[i] = {RESET_ATTR, CH_BLANK};
		cursor_pos = 0;
		text_attr = RESET_ATTR;
	endtask

	task automatic scroll_if_past_end();
		if (cursor_pos < CELLS)
			return;
		for (int i = 0; i < CELLS - COLUMNS; i++)
			screen[i] = screen[i + COLUMNS];
		for (int i = CELLS - COLUMNS; i < CELLS; i++)
			screen[i] = {text_attr, CH_BLANK};
		cursor_pos = CELLS - COLUMNS;
		scroll_total++;
	endtask

	// The cell under the cursor takes the current attribute so the cursor shows.
	task automatic mark_cursor();
		if (cursor_pos < CELLS)
			screen[cursor_pos][15:8] = text_attr;
	endtask

	task automatic place_glyph(input logic [7:0] ch);
		if (cursor_pos < CELLS)
			screen[cursor_pos] = {text_attr, ch};
		cursor_pos++;
		scroll_if_past_end();
		mark_cursor();
	endtask

	task automatic put_byte(input logic [7:0] ch);
		int unsigned n;
		if (ch == CH_NL) begin
			cursor_pos = (cursor_pos / COLUMNS + 1) * COLUMNS;
		end else if (ch == CH_TAB) begin
			n = TAB_STOP - (cursor_pos % TAB_STOP);
			repeat (n) place_glyph(CH_BLANK);
		end else if (ch == CH_BS) begin
			if (cursor_pos >= 1)
				cursor_pos--;
			place_glyph(CH_BLANK);
			cursor_pos--;
		end else begin
			place_glyph(ch);
			return;
		end
		scroll_if_past_end();
		mark_cursor();
	endtask

	task automatic apply_request(input logic [1:0] k, input logic [7:0] ch,
			input logic [10:0] idx, input logic [7:0] pv, output cell_answer_t ans);
		ans = '0;
		case (k)
			KIND_PUT: begin
				put_byte(ch);
			end
			KIND_READ: begin
				if (idx < CELLS) begin
					ans.ch = screen[idx][7:0];
					ans.attr = screen[idx][15:8];
				end
			end
			KIND_POST: begin
				screen[CELLS - 2] = {text_attr, hex_ascii(pv[7:4])};
				screen[CELLS - 1] = {text_attr, hex_ascii(pv[3:0])};
			end
			default: begin
			end
		endcase
		ans.cursor = cursor_pos[10:0];
	endtask

	always @(posedge clk) begin : watch
		cell_answer_t want_ans;
		cell_answer_t new_ans;
		if (!arst_n) begin
			clear_screen();
			answer_q.delete();
		end else begin
			// Results are compared before a new request is predicted in the same cycle.
			if (done) begin
				if (answer_q.size() == 0) begin
					report_mismatch($sformatf("result with no request pending, cursor %0d",
						cursor_cell));
				end else begin
					want_ans = answer_q.pop_front();
					checked_total++;
					if (cursor_cell !== want_ans.cursor)
						report_mismatch($sformatf("cursor_cell got %0d, expected %0d",
							cursor_cell, want_ans.cursor));
					if (cell_char !== want_ans.ch)
						report_mismatch($sformatf("cell_char got %02h, expected %02h",
							cell_char, want_ans.ch));
					if (cell_attr !== want_ans.attr)
						report_mismatch($sformatf("cell_attr got %02h, expected %02h",
							cell_attr, want_ans.attr));
				end
			end
			if (cfg_we)
				text_attr = cfg_wdata;
			if (start && !busy) begin
				apply_request(kind, char_code, cell_index, post_value, new_ans);
				answer_q.push_back(new_ans);
			end
		end
		mismatches <= err_total;
		outstanding <= answer_q.size();
		checked <= checked_total;
		scrolls <= scroll_total;
	end

endmodule

// ----- tb/tb_text_console_writer_core.sv -----
module tb_text_console_writer_core;
	import tcw_pkg::*;

	// Kind code the block leaves unused; it must change nothing.
	localparam logic [1:0] KIND_SPARE = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  kind = KIND_PUT;
	logic [7:0]  char_code = 8'h00;
	logic [10:0] cell_index = 11'd0;
	logic [7:0]  post_value = 8'h00;
	logic        done;
	logic [10:0] cursor_cell;
	logic [7:0]  cell_char;
	logic [7:0]  cell_attr;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = 8'h00;

	int mismatches;
	int outstanding;
	int checked;
	int scrolls;
	int sent = 0;
	int attr_settings = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	text_console_writer_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.char_code(char_code),
		.cell_index(cell_index),
		.post_value(post_value),
		.done(done),
		.cursor_cell(cursor_cell),
		.cell_char(cell_char),
		.cell_attr(cell_attr),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	text_console_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.char_code(char_code),
		.cell_index(cell_index),
		.post_value(post_value),
		.done(done),
		.cursor_cell(cursor_cell),
		.cell_char(cell_char),
		.cell_attr(cell_attr),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.checked(checked),
		.scrolls(scrolls)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return 0;
		else if (r < 85)
			return $urandom_range(3, 1);
		else if (r < 97)
			return $urandom_range(12, 4);
		else
			return $urandom_range(60, 20);
	endfunction

	function automatic logic [7:0] pick_char(input int nl_pct);
		int r;
		r = $urandom_range(99);
		if (r < nl_pct)
			return CH_NL;
		else if (r < nl_pct + 8)
			return CH_TAB;
		else if (r < nl_pct + 15)
			return CH_BS;
		else if (r < nl_pct + 22)
			return 8'($urandom_range(255));
		else
			return 8'($urandom_range(8'h7E, 8'h21));
	endfunction

	// Reads lean toward the bottom rows, the top rows and the post code cells.
	function automatic logic [10:0] pick_index();
		int r;
		r = $urandom_range(99);
		if (r < 30)
			return 11'($urandom_range(1999, 1840));
		else if (r < 50)
			return 11'($urandom_range(159, 0));
		else if (r < 75)
			return 11'($urandom_range(1999, 0));
		else if (r < 88)
			return 11'($urandom_range(1999, 1998));
		else
			return 11'($urandom_range(2047, 0));
	endfunction

	// Holds the request until the block takes it; start stays high afterwards.
	task automatic send_request(input logic [1:0] k, input logic [7:0] ch,
			input logic [10:0] idx, input logic [7:0] pv);
		start <= 1'b1;
		kind <= k;
		char_code <= ch;
		cell_index <= idx;
		post_value <= pv;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	// Fields carry noise while start is low.
	task automatic pause(input int n);
		if (n > 0) begin
			start <= 1'b0;
			kind <= 2'($urandom);
			char_code <= 8'($urandom);
			cell_index <= 11'($urandom);
			post_value <= 8'($urandom);
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain(input int limit);
		int waited;
		waited = 0;
		start <= 1'b0;
		@(posedge clk);
		while ((outstanding != 0 || busy) && waited < limit) begin
			@(posedge clk);
			waited++;
		end
	endtask

	task automatic write_attr(input logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		attr_settings++;
		@(posedge clk);
	endtask

	task automatic random_phase(input int count, input int nl_pct, input int put_pct);
		int r;
		logic [7:0] ch;
		logic [10:0] idx;
		logic [7:0] pv;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			ch = 8'($urandom);
			idx = 11'($urandom);
			pv = 8'($urandom);
			if (r < put_pct)
				send_request(KIND_PUT, pick_char(nl_pct), idx, pv);
			else if (r < put_pct + 22)
				send_request(KIND_READ, ch, pick_index(), pv);
			else if (r < put_pct + 28)
				send_request(KIND_POST, ch, idx, pv);
			else
				send_request(KIND_SPARE, ch, idx, pv);
			// Every few dozen requests, a run goes back to back.
			if ((i % 40) < 8)
				pause(0);
			else
				pause(pick_gap());
		end
	endtask

	task automatic directed_phase();
		send_request(KIND_READ, 8'h00, 11'd0, 8'h00);       pause(pick_gap());
		send_request(KIND_READ, 8'hFF, 11'd1999, 8'hFF);    pause(pick_gap());
		send_request(KIND_READ, 8'h00, 11'd2000, 8'h00);    pause(pick_gap());
		send_request(KIND_READ, 8'hFF, 11'd2047, 8'hFF);    pause(pick_gap());
		send_request(KIND_SPARE, 8'hFF, 11'd2047, 8'hFF);   pause(pick_gap());
		// Backspace with the cursor already at the first cell.
		send_request(KIND_PUT, CH_BS, 11'd0, 8'h00);        pause(pick_gap());
		send_request(KIND_PUT, 8'h00, 11'd0, 8'h00);        pause(pick_gap());
		send_request(KIND_PUT, 8'hFF, 11'd0, 8'h00);        pause(pick_gap());
		send_request(KIND_PUT, CH_TAB, 11'd0, 8'h00);       pause(pick_gap());
		send_request(KIND_PUT, 8'h41, 11'd0, 8'h00);        pause(pick_gap());
		send_request(KIND_PUT, CH_BS, 11'd0, 8'h00);        pause(pick_gap());
		send_request(KIND_PUT, CH_NL, 11'd0, 8'h00);        pause(pick_gap());
		send_request(KIND_READ, 8'h00, 11'd0, 8'h00);       pause(pick_gap());
		send_request(KIND_READ, 8'h00, 11'd1, 8'h00);       pause(pick_gap());
		send_request(KIND_READ, 8'h00, 11'd8, 8'h00);       pause(pick_gap());
		send_request(KIND_READ, 8'h00, 11'd9, 8'h00);       pause(pick_gap());
		send_request(KIND_POST, 8'h00, 11'd0, 8'h00);       pause(pick_gap());
		send_request(KIND_READ, 8'h00, 11'd1998, 8'h00);    pause(pick_gap());
		send_request(KIND_POST, 8'h00, 11'd0, 8'hFF);       pause(pick_gap());
		send_request(KIND_POST, 8'h00, 11'd0, 8'h5A);       pause(pick_gap());
		send_request(KIND_READ, 8'h00, 11'd1998, 8'h00);    pause(pick_gap());
		send_request(KIND_READ, 8'h00, 11'd1999, 8'h00);    pause(pick_gap());
		send_request(KIND_PUT, CH_TAB, 11'd0, 8'h00);       pause(pick_gap());
		send_request(KIND_READ, 8'h00, 11'h555, 8'h00);     pause(pick_gap());
		send_request(KIND_READ, 8'h00, 11'h2AA, 8'h00);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// The first requests wait out the clearing sweep after reset.
		directed_phase();
		drain(20000);
		write_attr(8'h00);
		random_phase(60, 18, 60);
		drain(20000);
		write_attr(8'hFF);
		random_phase(60, 2, 70);
		drain(20000);
		write_attr(8'($urandom));
		random_phase(60, 25, 55);
		drain(20000);
		write_attr(8'h1E);
		random_phase(60, 3, 70);
		drain(20000);
		write_attr(8'($urandom));
		random_phase(60, 15, 60);
		drain(20000);
		repeat (16) @(posedge clk);

		$display("run covered %0d requests under %0d attribute settings plus the reset one",
			sent, attr_settings);
		$display("%0d results compared, %0d screen scrolls predicted", checked, scrolls);
		if (outstanding != 0)
			$display("%0d expected results never arrived", outstanding);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb_text_console_writer_core: done, clean");
		end else begin
			$display("tb_text_console_writer_core: done, errors");
		end
		$finish;
	end

	initial begin
		#12000000;
		$display("timeout: the run did not finish in time");
		$display("tb_text_console_writer_core: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_cursor.sv
rtl/tcw_seq.sv
rtl/text_console_writer_core.sv
tb/text_console_checker.sv
tb/tb_text_console_writer_core.sv
